@@ rtl/bankers_safe_allocation_core_assert.svh @@
// Assertion macros used by the allocator core RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef BANKERS_SAFE_ALLOCATION_CORE_ASSERT_SVH
`define BANKERS_SAFE_ALLOCATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bsa_pkg.sv @@
// Shared types, codes and sizes for the banker's allocator.
// No dependencies.
`default_nettype none
package bsa_pkg;
    localparam int PROCS     = 5;
    localparam int RESOURCES = 4;
    localparam int LANES     = 4;
    localparam int CW        = 8;
    localparam int AW        = 12;
    localparam int IW        = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int CNTW      = $clog2(PROCS + 1);
    localparam int ENTRIES   = 8;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RUN     = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] ST_GRANTED     = 3'd0;
    localparam logic [2:0] ST_OVER_NEED   = 3'd1;
    localparam logic [2:0] ST_OVER_AVAIL  = 3'd2;
    localparam logic [2:0] ST_UNSAFE      = 3'd3;
    localparam logic [2:0] ST_OVER_CLAIM  = 3'd4;
    localparam logic [2:0] ST_OVER_ALLOC  = 3'd5;
    localparam logic [2:0] ST_BAD_PROCESS = 3'd6;

    localparam logic [2:0] CFG_CLAIMS_P0_P1 = 3'd0;
    localparam logic [2:0] CFG_CLAIMS_P2_P3 = 3'd1;
    localparam logic [2:0] CFG_CLAIMS_P4_P5 = 3'd2;
    localparam logic [2:0] CFG_CLAIMS_P6_P7 = 3'd3;
    localparam logic [2:0] CFG_TOTAL        = 3'd4;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] process;
        logic [7:0] amount_r0;
        logic [7:0] amount_r1;
        logic [7:0] amount_r2;
        logic [7:0] amount_r3;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] sequence_process;
        logic       last;
    } result_t;

    typedef logic [LANES-1:0][AW-1:0] acc_vec_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  addr;
        logic [31:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic need_fits;
        logic amt_over_need;
        logic amt_over_work;
        logic amt_over_claim;
        logic amt_over_alloc;
    } vec_flags_t;
endpackage
`default_nettype wire

@@ rtl/bsa_table.sv @@
// Allocation table: eight 32-bit entries, one read address, one write, bulk clear.
// Depends on bsa_pkg.
`default_nettype none
module bsa_table (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [2:0]       rd_addr,
    output logic [31:0]           rd_data,
    input  wire bsa_pkg::tbl_wr_t wr,
    input  wire logic             clear
);
    import bsa_pkg::*;

    logic [31:0] entry_reg [ENTRIES];

    // Update entries; clear wins over a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                entry_reg[i] <= '0;
        end
        else if (clear)
        begin
            for (int i = 0; i < ENTRIES; i++)
                entry_reg[i] <= '0;
        end
        else if (wr.en)
        begin
            entry_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = entry_reg[rd_addr];
endmodule
`default_nettype wire

@@ rtl/bsa_vec_unit.sv @@
// Shared lane unit: per-resource compares and adds for one process at a time.
// Depends on bsa_pkg.
`default_nettype none
module bsa_vec_unit (
    input  wire bsa_pkg::acc_vec_t   work,
    input  wire logic [31:0]         alloc,
    input  wire logic [31:0]         claim,
    input  wire logic [31:0]         amt,
    output bsa_pkg::vec_flags_t      flags,
    output bsa_pkg::acc_vec_t        work_add_alloc,
    output bsa_pkg::acc_vec_t        work_sub_alloc,
    output bsa_pkg::acc_vec_t        work_sub_amt,
    output logic [31:0]              alloc_add_amt,
    output logic [31:0]              alloc_sub_amt
);
    import bsa_pkg::*;

    // Evaluate each resource lane; unused lanes never fail and keep their value
    always_comb
    begin
        logic signed [AW-1:0] a_s;
        logic signed [AW-1:0] c_s;
        logic signed [AW-1:0] m_s;
        logic signed [AW-1:0] w_s;
        logic signed [AW-1:0] need_s;
        flags = '{need_fits: 1'b1, default: 1'b0};
        work_add_alloc = work;
        work_sub_alloc = work;
        work_sub_amt   = work;
        alloc_add_amt  = alloc;
        alloc_sub_amt  = alloc;
        for (int r = 0; r < LANES; r++)
        begin
            a_s    = $signed({{(AW-CW){1'b0}}, alloc[CW*r +: CW]});
            c_s    = $signed({{(AW-CW){1'b0}}, claim[CW*r +: CW]});
            m_s    = $signed({{(AW-CW){1'b0}}, amt[CW*r +: CW]});
            w_s    = $signed(work[r]);
            need_s = c_s - a_s;
            if (r < RESOURCES)
            begin
                if (need_s > w_s) flags.need_fits = 1'b0;
                if (m_s > need_s) flags.amt_over_need = 1'b1;
                if (m_s > w_s)    flags.amt_over_work = 1'b1;
                if (m_s > c_s)    flags.amt_over_claim = 1'b1;
                if (m_s > a_s)    flags.amt_over_alloc = 1'b1;
                work_add_alloc[r] = AW'(w_s + a_s);
                work_sub_alloc[r] = AW'(w_s - a_s);
                work_sub_amt[r]   = AW'(w_s - m_s);
                alloc_add_amt[CW*r +: CW] = alloc[CW*r +: CW] + amt[CW*r +: CW];
                alloc_sub_amt[CW*r +: CW] = alloc[CW*r +: CW] - amt[CW*r +: CW];
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/bankers_safe_allocation_core.sv @@
// Banker's allocator: one transaction at a time, busy while it is worked on.
// Request: AVAIL, CHECK, then SAFE and FINISH if granted; release: AVAIL, CHECK.
// Run: AVAIL, SAFE, FINISH, then if safe PROCS results on consecutive cycles.
// The safety scan takes one process per cycle through the lane unit.
// Results show for one cycle each under strobe; the receiver cannot stall.
// Reset (async, active low) clears claims, totals and the allocation table.
`default_nettype none
`include "bankers_safe_allocation_core_assert.svh"
module bankers_safe_allocation_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire bsa_pkg::cmd_t   cmd,
    output logic                 strobe,
    output bsa_pkg::result_t     result,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [63:0]     cfg_data
);
    import bsa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_AVAIL  = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SAFE   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]      state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    acc_vec_t        acc_reg, acc_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   pass_reg, pass_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [PROCS-1:0] done_reg, done_next;
    logic [2:0]      seq_reg [PROCS];
    logic [31:0]     saved_reg, saved_next;
    logic            strobe_reg, strobe_next;
    result_t         result_reg, result_next;
    logic [31:0]     claim_reg [ENTRIES];
    logic [31:0]     total_reg;

    logic [2:0]      rd_addr;
    logic [31:0]     alloc_rd;
    tbl_wr_t         tbl_wr;
    logic            tbl_clear;
    logic            seq_we;
    logic [31:0]     amt_vec;
    vec_flags_t      flags;
    acc_vec_t        work_add_alloc, work_sub_alloc, work_sub_amt;
    logic [31:0]     alloc_add_amt, alloc_sub_amt;

    assign amt_vec = {cmd_reg.amount_r3, cmd_reg.amount_r2,
                      cmd_reg.amount_r1, cmd_reg.amount_r0};
    assign rd_addr = (state_reg == S_CHECK || state_reg == S_FINISH) ?
                     cmd_reg.process : 3'(idx_reg);

    bsa_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (alloc_rd),
        .wr      (tbl_wr),
        .clear   (tbl_clear)
    );

    bsa_vec_unit u_vec (
        .work           (acc_reg),
        .alloc          (alloc_rd),
        .claim          (claim_reg[rd_addr]),
        .amt            (amt_vec),
        .flags          (flags),
        .work_add_alloc (work_add_alloc),
        .work_sub_alloc (work_sub_alloc),
        .work_sub_amt   (work_sub_amt),
        .alloc_add_amt  (alloc_add_amt),
        .alloc_sub_amt  (alloc_sub_amt)
    );

    // Store configuration; writes beyond the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                claim_reg[i] <= '0;
            total_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLAIMS_P0_P1, CFG_CLAIMS_P2_P3, CFG_CLAIMS_P4_P5, CFG_CLAIMS_P6_P7:
                begin
                    claim_reg[{cfg_index[1:0], 1'b0}] <= cfg_data[31:0];
                    claim_reg[{cfg_index[1:0], 1'b1}] <= cfg_data[63:32];
                end
                CFG_TOTAL: total_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        pass_next   = pass_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        saved_next  = saved_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        tbl_wr      = '{en: 1'b0, addr: cmd_reg.process, data: alloc_add_amt};
        tbl_clear   = 1'b0;
        seq_we      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    idx_next = '0;
                    for (int r = 0; r < LANES; r++)
                        acc_next[r] = {{(AW-CW){1'b0}}, total_reg[CW*r +: CW]};
                    if (cmd.operation == OP_NONE)
                        state_next = S_IDLE;
                    else if (cmd.operation != OP_RUN && 32'(cmd.process) >= PROCS)
                    begin
                        strobe_next = 1'b1;
                        result_next = '{status: ST_BAD_PROCESS, sequence_process: 3'd0,
                                        last: 1'b1};
                    end
                    else
                        state_next = S_AVAIL;
                end
            end
            S_AVAIL:
            begin
                acc_next = work_sub_alloc;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IW'(PROCS - 1))
                begin
                    idx_next   = '0;
                    pass_next  = '0;
                    count_next = '0;
                    done_next  = '0;
                    state_next = (cmd_reg.operation == OP_RUN) ? S_SAFE : S_CHECK;
                end
            end
            S_CHECK:
            begin
                strobe_next = 1'b1;
                result_next = '{status: ST_GRANTED, sequence_process: 3'd0, last: 1'b1};
                state_next  = S_IDLE;
                if (cmd_reg.operation == OP_REQUEST)
                begin
                    if (flags.amt_over_need)
                        result_next.status = ST_OVER_NEED;
                    else if (flags.amt_over_work)
                        result_next.status = ST_OVER_AVAIL;
                    else
                    begin
                        // Grant tentatively, then scan for a safe order
                        strobe_next = 1'b0;
                        tbl_wr.en   = 1'b1;
                        saved_next  = alloc_rd;
                        acc_next    = work_sub_amt;
                        state_next  = S_SAFE;
                    end
                end
                else
                begin
                    if (flags.amt_over_claim)
                        result_next.status = ST_OVER_CLAIM;
                    else if (flags.amt_over_alloc)
                        result_next.status = ST_OVER_ALLOC;
                    else
                    begin
                        tbl_wr.en   = 1'b1;
                        tbl_wr.data = alloc_sub_amt;
                    end
                end
            end
            S_SAFE:
            begin
                // Append a waiting process whose need fits the work vector
                if (!done_reg[idx_reg] && flags.need_fits)
                begin
                    done_next[idx_reg] = 1'b1;
                    seq_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    acc_next   = work_add_alloc;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IW'(PROCS - 1))
                begin
                    idx_next  = '0;
                    pass_next = pass_reg + 1'b1;
                    if (pass_reg == IW'(PROCS - 1))
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (count_reg == CNTW'(PROCS) && cmd_reg.operation == OP_RUN)
                    state_next = S_EMIT;
                else
                begin
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                    result_next = '{status: ST_GRANTED, sequence_process: 3'd0,
                                    last: 1'b1};
                    if (count_reg != CNTW'(PROCS))
                    begin
                        result_next.status = ST_UNSAFE;
                        // Roll back the tentative grant
                        if (cmd_reg.operation == OP_REQUEST)
                        begin
                            tbl_wr.en   = 1'b1;
                            tbl_wr.data = saved_reg;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                strobe_next = 1'b1;
                result_next = '{status: ST_GRANTED, sequence_process: seq_reg[idx_reg],
                                last: (idx_reg == IW'(PROCS - 1))};
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IW'(PROCS - 1))
                begin
                    tbl_clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            idx_reg    <= '0;
            pass_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            idx_reg    <= idx_next;
            pass_reg   <= pass_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        acc_reg    <= acc_next;
        saved_reg  <= saved_next;
        result_reg <= result_next;
        if (seq_we)
            seq_reg[count_reg[IW-1:0]] <= 3'(idx_reg);
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    `BSA_ASSERT_NEXT(a_burst_continues, strobe && !result.last, strobe, "run burst broke off")
    `BSA_ASSERT_NOW(a_fail_is_last, strobe && result.status != ST_GRANTED, result.last,
        "failed transaction gave more than one result")
    `BSA_ASSERT_NEXT(a_run_goes_busy, start && !busy && cmd.operation == OP_RUN, busy,
        "run transaction did not start the scan")
    `BSA_ASSERT_NOW(a_burst_while_busy, strobe && !result.last, busy,
        "sequence result outside the emit phase")
endmodule
`default_nettype wire
